### hdl/json_string_unescape_utf8_unit_assert.svh
// ----------------------------------------------------------------------------
// json string unescape unit assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH

// same-cycle implication
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and constants of the json string unescape unit
// ----------------------------------------------------------------------------
package jsu_pkg;

  // result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA = 2'd0;
  localparam kind_t KIND_DONE = 2'd1;
  localparam kind_t KIND_ERR  = 2'd2;

  // defaults
  localparam logic [15:0] MAX_LEN_RESET  = 16'd8192;
  localparam int          CMD_FIFO_DEPTH = 4;

  // command from decoder front to byte emitter
  typedef struct packed {
    kind_t       kind;
    logic [20:0] cp;
    logic [1:0]  nb_m1;
  } cmd_t;

endpackage

### hdl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// source byte channel: start request, text end marker and raw byte
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic       text_end;
  logic [7:0] in_byte;

  modport source (output valid, start_req, text_end, in_byte, input ready);
  modport sink (input valid, start_req, text_end, in_byte, output ready);
endinterface

### hdl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// result channel: kind, decoded byte and last marker
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, kind, out_byte, last, input ready);
  modport sink (input valid, kind, out_byte, last, output ready);
endinterface

### hdl/jsu_cfg_if.sv
// ----------------------------------------------------------------------------
// jsu_cfg_if
// configuration write channel for the max_length register
// ----------------------------------------------------------------------------
interface jsu_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_length;

  modport source (output valid, max_length, input ready);
  modport sink (input valid, max_length, output ready);
endinterface

### hdl/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// json string literal decoder with utf-8 validation and re-encoding
// ----------------------------------------------------------------------------
// A source byte is taken every cycle while the command queue between the
// decoder and the byte emitter has room; the decoder state is updated as each byte is taken.
// Each decoded code point leaves as 1 to 4 utf-8 bytes and each string end or
// error as one status result, one result per cycle from the emitter's output
// register while the sink is ready, so the sustained rate is one source byte
// per cycle for text whose output is no longer than its input and otherwise one
// output byte per cycle. The queue (FIFO_DEPTH commands) absorbs the extra
// bytes of multi-byte characters. The max_length port is always ready and is
// meant to be written while no string is in flight.
module json_string_unescape_utf8_unit #(
  parameter int FIFO_DEPTH = jsu_pkg::CMD_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch,
  jsu_cfg_if.sink    cfg_ch
);
  import jsu_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_push_data;
  logic q_pop;
  cmd_t q_pop_data;
  logic q_valid;

  // decoder front
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .cmd_push (q_push),
    .cmd      (q_push_data)
  );

  // command queue
  jsu_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_valid)
  );

  // byte emitter
  jsu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### hdl/jsu_cmd_fifo.sv
`include "json_string_unescape_utf8_unit_assert.svh"
// ----------------------------------------------------------------------------
// jsu_cmd_fifo
// short command queue between the decoder front and the byte emitter
// ----------------------------------------------------------------------------
module jsu_cmd_fifo #(
  parameter int DEPTH = jsu_pkg::CMD_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output jsu_pkg::cmd_t pop_data,
  output logic          not_empty
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `JSU_ASSERT_IMP(a_no_push_full, push, !full, "command pushed into full queue")
  `JSU_ASSERT_IMP(a_no_pop_empty, pop, not_empty, "command popped from empty queue")
  `JSU_ASSERT_NXT(a_cnt_grow, push && !pop, cnt_r == ($past(cnt_r) + CNT_W'(1)),
                  "queue count did not grow on push")

endmodule

### hdl/jsu_front.sv
`include "json_string_unescape_utf8_unit_assert.svh"
// ----------------------------------------------------------------------------
// jsu_front
// per-byte decoder: escapes, surrogate pairs, utf-8 checks and length limit
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  jsu_in_if.sink        in_ch,
  jsu_cfg_if.sink       cfg_ch,
  input  logic          q_full,
  output logic          cmd_push,
  output jsu_pkg::cmd_t cmd
);
  import jsu_pkg::*;

  // decoder phases
  localparam logic [3:0] PH_HALT   = 4'd0;
  localparam logic [3:0] PH_WS     = 4'd1;
  localparam logic [3:0] PH_BODY   = 4'd2;
  localparam logic [3:0] PH_ESC    = 4'd3;
  localparam logic [3:0] PH_HEXHI  = 4'd4;
  localparam logic [3:0] PH_WANTBS = 4'd5;
  localparam logic [3:0] PH_WANTU  = 4'd6;
  localparam logic [3:0] PH_HEXLO  = 4'd7;
  localparam logic [3:0] PH_CONT   = 4'd8;

  // characters
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // sequence classes
  localparam logic [1:0] SEQ_2B = 2'd1;
  localparam logic [1:0] SEQ_3B = 2'd2;

  // hex digit decode: valid flag and value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [20:0] code_r, code_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic [1:0]  cont_left_r, cont_left_nxt;
  logic [1:0]  seq_cls_r, seq_cls_nxt;
  logic [16:0] out_cnt_r, out_cnt_nxt;
  logic [15:0] max_len_r;

  logic        acc;
  logic [7:0]  c;
  logic [4:0]  hx;
  logic [3:0]  ph_b;
  logic        emit_req;
  logic [20:0] emit_cp;
  logic        fin_req;
  kind_t       fin_kind;
  logic [1:0]  nb_m1;
  logic [16:0] cnt_sum;
  logic [20:0] lo_bound;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign acc          = in_ch.valid && in_ch.ready;
  assign c            = in_ch.in_byte;
  assign hx           = hex_decode(c);

  // byte decoder
  always_comb begin
    ph_b          = in_ch.start_req ? PH_WS : phase_r;
    phase_nxt     = ph_b;
    hex_cnt_nxt   = in_ch.start_req ? 2'd0 : hex_cnt_r;
    code_nxt      = in_ch.start_req ? 21'd0 : code_r;
    hs_nxt        = in_ch.start_req ? 10'd0 : hs_r;
    cont_left_nxt = in_ch.start_req ? 2'd0 : cont_left_r;
    seq_cls_nxt   = in_ch.start_req ? 2'd0 : seq_cls_r;
    out_cnt_nxt   = in_ch.start_req ? 17'd0 : out_cnt_r;
    emit_req      = 1'b0;
    emit_cp       = 21'd0;
    fin_req       = 1'b0;
    fin_kind      = KIND_ERR;
    lo_bound      = 21'h10000;

    if (ph_b != PH_HALT) begin
      if (in_ch.text_end) begin
        fin_req = 1'b1;
      end else begin
        unique case (ph_b)
          PH_WS: begin
            if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF) begin
              phase_nxt = PH_WS;
            end else if (c == CH_QUOTE) begin
              phase_nxt = PH_BODY;
            end else begin
              fin_req = 1'b1;
            end
          end
          PH_BODY: begin
            if (c == CH_QUOTE) begin
              fin_req  = 1'b1;
              fin_kind = KIND_DONE;
            end else if (c < 8'h20) begin
              fin_req = 1'b1;
            end else if (c == CH_BSLASH) begin
              phase_nxt = PH_ESC;
            end else if (c < 8'h80) begin
              emit_req = 1'b1;
              emit_cp  = {13'd0, c};
            end else if (c >= 8'hc2 && c <= 8'hdf) begin
              seq_cls_nxt   = SEQ_2B;
              cont_left_nxt = 2'd1;
              code_nxt      = {16'd0, c[4:0]};
              phase_nxt     = PH_CONT;
            end else if (c >= 8'he0 && c <= 8'hef) begin
              seq_cls_nxt   = SEQ_3B;
              cont_left_nxt = 2'd2;
              code_nxt      = {17'd0, c[3:0]};
              phase_nxt     = PH_CONT;
            end else if (c >= 8'hf0 && c <= 8'hf4) begin
              seq_cls_nxt   = 2'd3;
              cont_left_nxt = 2'd3;
              code_nxt      = {18'd0, c[2:0]};
              phase_nxt     = PH_CONT;
            end else begin
              fin_req = 1'b1;
            end
          end
          PH_ESC: begin
            unique case (c) inside
              CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                emit_req = 1'b1;
                emit_cp  = {13'd0, c};
              end
              CH_B: begin
                emit_req = 1'b1;
                emit_cp  = 21'd8;
              end
              CH_F: begin
                emit_req = 1'b1;
                emit_cp  = 21'd12;
              end
              CH_N: begin
                emit_req = 1'b1;
                emit_cp  = 21'd10;
              end
              CH_R: begin
                emit_req = 1'b1;
                emit_cp  = 21'd13;
              end
              CH_T: begin
                emit_req = 1'b1;
                emit_cp  = 21'd9;
              end
              CH_U: begin
                phase_nxt   = PH_HEXHI;
                hex_cnt_nxt = 2'd0;
                code_nxt    = 21'd0;
              end
              default: fin_req = 1'b1;
            endcase
          end
          PH_HEXHI, PH_HEXLO: begin
            if (!hx[4]) begin
              fin_req = 1'b1;
            end else begin
              code_nxt = {5'd0, code_nxt[11:0], hx[3:0]};
              if (hex_cnt_nxt != 2'd3) begin
                hex_cnt_nxt = hex_cnt_nxt + 2'd1;
              end else begin
                hex_cnt_nxt = 2'd0;
                if (ph_b == PH_HEXHI) begin
                  // high surrogate waits for its partner
                  if (code_nxt[15:10] == 6'b110110) begin
                    hs_nxt    = code_nxt[9:0];
                    phase_nxt = PH_WANTBS;
                  end else if (code_nxt[15:10] == 6'b110111) begin
                    fin_req = 1'b1;
                  end else begin
                    emit_req = 1'b1;
                    emit_cp  = code_nxt;
                  end
                end else begin
                  // low surrogate joins the pair
                  if (code_nxt[15:10] != 6'b110111) begin
                    fin_req = 1'b1;
                  end else begin
                    emit_req = 1'b1;
                    emit_cp  = {{1'b0, hs_nxt} + 11'd64, code_nxt[9:0]};
                  end
                end
              end
            end
          end
          PH_WANTBS: begin
            if (c != CH_BSLASH) begin
              fin_req = 1'b1;
            end else begin
              phase_nxt = PH_WANTU;
            end
          end
          PH_WANTU: begin
            if (c != CH_U) begin
              fin_req = 1'b1;
            end else begin
              phase_nxt   = PH_HEXLO;
              hex_cnt_nxt = 2'd0;
              code_nxt    = 21'd0;
            end
          end
          PH_CONT: begin
            if (c[7:6] != 2'b10) begin
              fin_req = 1'b1;
            end else begin
              code_nxt = {code_nxt[14:0], c[5:0]};
              if (cont_left_nxt > 2'd1) begin
                cont_left_nxt = cont_left_nxt - 2'd1;
              end else begin
                cont_left_nxt = 2'd0;
                if (seq_cls_nxt == SEQ_2B) begin
                  lo_bound = 21'h80;
                end else if (seq_cls_nxt == SEQ_3B) begin
                  lo_bound = 21'h800;
                end
                // overlong, out of range or encoded surrogate
                if (code_nxt < lo_bound || code_nxt > 21'h10ffff ||
                    (code_nxt >= 21'hd800 && code_nxt <= 21'hdfff)) begin
                  fin_req = 1'b1;
                end else begin
                  emit_req = 1'b1;
                  emit_cp  = code_nxt;
                end
              end
            end
          end
          default: fin_req = 1'b1;
        endcase
      end
    end

    // encoded length and output limit
    if (emit_cp < 21'h80) begin
      nb_m1 = 2'd0;
    end else if (emit_cp < 21'h800) begin
      nb_m1 = 2'd1;
    end else if (emit_cp < 21'h10000) begin
      nb_m1 = 2'd2;
    end else begin
      nb_m1 = 2'd3;
    end
    cnt_sum = out_cnt_nxt + {15'd0, nb_m1} + 17'd1;
    if (emit_req) begin
      if (cnt_sum > {1'b0, max_len_r}) begin
        fin_req  = 1'b1;
        fin_kind = KIND_ERR;
      end else begin
        out_cnt_nxt = cnt_sum;
        phase_nxt   = PH_BODY;
      end
    end
    if (fin_req) begin
      phase_nxt = PH_HALT;
    end
  end

  // command to the emitter
  assign cmd_push  = acc && (emit_req || fin_req);
  assign cmd.kind  = fin_req ? fin_kind : KIND_DATA;
  assign cmd.cp    = emit_cp;
  assign cmd.nb_m1 = nb_m1;

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HALT;
      hex_cnt_r   <= 2'd0;
      code_r      <= 21'd0;
      hs_r        <= 10'd0;
      cont_left_r <= 2'd0;
      seq_cls_r   <= 2'd0;
      out_cnt_r   <= 17'd0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      hex_cnt_r   <= hex_cnt_nxt;
      code_r      <= code_nxt;
      hs_r        <= hs_nxt;
      cont_left_r <= cont_left_nxt;
      seq_cls_r   <= seq_cls_nxt;
      out_cnt_r   <= out_cnt_nxt;
    end
  end

  // length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      max_len_r <= cfg_ch.max_length;
    end
  end

  `JSU_ASSERT_NXT(a_halt_after_end, cmd_push && cmd.kind != KIND_DATA, phase_r == PH_HALT,
                  "decoder not halted after complete or error")
  `JSU_ASSERT_IMP(a_cp_range, cmd_push && cmd.kind == KIND_DATA, cmd.cp <= 21'h10ffff,
                  "emitted code point out of range")
  `JSU_ASSERT_IMP(a_ascii_len, cmd_push && cmd.kind == KIND_DATA,
                  (cmd.cp < 21'h80) == (cmd.nb_m1 == 2'd0),
                  "encoded length does not match code point")

endmodule

### hdl/jsu_back.sv
`include "json_string_unescape_utf8_unit_assert.svh"
// ----------------------------------------------------------------------------
// jsu_back
// byte emitter: turns queued commands into utf-8 bytes and status results
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  jsu_pkg::cmd_t q_cmd,
  output logic          q_pop,
  jsu_out_if.source     out_ch
);
  import jsu_pkg::*;

  logic       out_valid_r;
  kind_t      kind_r;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic [1:0] idx_r;
  logic       load;
  logic [1:0] grp;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.last     = last_r;

  assign load  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = load && last_nxt;

  // utf-8 byte select: lead byte, then 6-bit groups high to low
  always_comb begin
    grp      = q_cmd.nb_m1 - idx_r;
    last_nxt = (q_cmd.kind != KIND_DATA) || (idx_r == q_cmd.nb_m1);
    byte_nxt = 8'd0;
    if (q_cmd.kind == KIND_DATA) begin
      if (idx_r != 2'd0) begin
        case (grp)
          2'd0:    byte_nxt = {2'b10, q_cmd.cp[5:0]};
          2'd1:    byte_nxt = {2'b10, q_cmd.cp[11:6]};
          default: byte_nxt = {2'b10, q_cmd.cp[17:12]};
        endcase
      end else begin
        case (q_cmd.nb_m1)
          2'd0:    byte_nxt = {1'b0, q_cmd.cp[6:0]};
          2'd1:    byte_nxt = {3'b110, q_cmd.cp[10:6]};
          2'd2:    byte_nxt = {4'b1110, q_cmd.cp[15:12]};
          default: byte_nxt = {5'b11110, q_cmd.cp[20:18]};
        endcase
      end
    end
  end

  // output register and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= last_nxt ? 2'd0 : idx_r + 2'd1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= q_cmd.kind;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  `JSU_ASSERT_IMP(a_status_last, out_valid_r && kind_r != KIND_DATA,
                  last_r && byte_r == 8'd0, "status result not last or carries data")
  `JSU_ASSERT_IMP(a_idx_bound, q_valid && q_cmd.kind == KIND_DATA, idx_r <= q_cmd.nb_m1,
                  "byte index beyond encoded length")
  `JSU_ASSERT_NXT(a_out_hold, out_valid_r && !out_ch.ready,
                  out_valid_r && $stable({kind_r, byte_r, last_r}),
                  "result changed while stalled")

endmodule
